>>> rtl/core/sqsw_pkg.sv
// Shared types and constants for the square channel with frequency sweep.
// No dependencies; imported by the channel core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sqsw_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [2:0] OFF_SWEEP    = 3'd0;
   localparam logic [2:0] OFF_DUTY     = 3'd1;
   localparam logic [2:0] OFF_ENVELOPE = 3'd2;
   localparam logic [2:0] OFF_FREQ_LOW = 3'd3;
   localparam logic [2:0] OFF_TRIGGER  = 3'd4;

   localparam logic [7:0] DUTY_TABLE [4] = '{8'h01, 8'h03, 8'h0F, 8'hFC};

   typedef struct packed {
      logic [1:0] kind;
      logic       fs_edge;
      logic [2:0] reg_offset;
      logic [7:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [3:0] amplitude;
      logic       channel_on;
      logic [7:0] read_data;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> rtl/core/sqsw_if.sv
// Valid/ready channel interfaces for request and response items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sqsw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       fs_edge;
   logic [2:0] reg_offset;
   logic [7:0] write_data;

   modport source (output valid, kind, fs_edge, reg_offset, write_data, input ready);
   modport sink (input valid, kind, fs_edge, reg_offset, write_data, output ready);
endinterface

interface sqsw_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] amplitude;
   logic       channel_on;
   logic [7:0] read_data;

   modport source (output valid, amplitude, channel_on, read_data, input ready);
   modport sink (input valid, amplitude, channel_on, read_data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sqsw_chan.sv
// Channel state and single-pass update for one item: registers, sweep,
// envelope, frequency timer, length counter. Depends on sqsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sqsw_chan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_go,
   input  sqsw_pkg::req_item_type     item,
   output sqsw_pkg::rsp_item_type     result
);
   import sqsw_pkg::*;

   typedef struct packed {
      logic [7:0]  sweep_reg;
      logic [7:0]  duty_reg;
      logic [7:0]  envelope_reg;
      logic [7:0]  freq_low_reg;
      logic [7:0]  trigger_reg;
      logic [11:0] shadow_freq;
      logic [3:0]  sweep_timer;
      logic        sweep_on;
      logic [2:0]  period_timer;
      logic [3:0]  cur_volume;
      logic [6:0]  length_count;
      logic [14:0] freq_timer;
      logic [2:0]  duty_pos;
      logic        enabled;
      logic [2:0]  frame_step;
   } chan_state_type;

   localparam chan_state_type STATE_RESET = '{
      sweep_timer:  4'd8,
      length_count: 7'd64,
      freq_timer:   15'd8192,
      default:      '0
   };

   chan_state_type state_ff;
   chan_state_type state_in;

   logic        run_sweep;
   logic        run_len;
   logic        run_env;
   logic [2:0]  sweep_per;
   logic [12:0] nf_first;
   logic [12:0] nf_second;
   logic [14:0] timer_next;
   logic [7:0]  rd;
   logic        duty_bit;

   function automatic logic [12:0] sweep_calc(logic [11:0] shadow, logic [7:0] sweep);
      logic [11:0] delta;
      delta = shadow >> sweep[2:0];
      if (sweep[3]) begin
         return {1'b0, shadow} - {1'b0, delta};
      end
      return {1'b0, shadow} + {1'b0, delta};
   endfunction

   function automatic logic [14:0] timer_period(logic [7:0] trig, logic [7:0] flow);
      logic [11:0] span;
      span = 12'd2048 - {1'b0, trig[2:0], flow};
      return {1'b0, span[11:0], 2'b00};
   endfunction

   always_comb begin
      state_in  = state_ff;
      run_sweep = 1'b0;
      run_len   = 1'b0;
      run_env   = 1'b0;
      sweep_per = state_ff.sweep_reg[6:4];
      nf_first  = '0;
      nf_second = '0;
      timer_next = '0;
      rd        = 8'hFF;

      case (item.kind)
         KIND_TICK: begin
            if (item.fs_edge) begin
               state_in.frame_step = state_ff.frame_step + 3'd1;
               run_sweep = (state_in.frame_step == 3'd2) || (state_in.frame_step == 3'd6);
               run_len   = ~state_in.frame_step[0];
               run_env   = (state_in.frame_step == 3'd7);
            end

            if (run_sweep) begin
               if (state_in.sweep_timer != 4'd0) begin
                  state_in.sweep_timer = state_in.sweep_timer - 4'd1;
               end
               if (state_in.sweep_timer == 4'd0) begin
                  state_in.sweep_timer = (sweep_per != 3'd0) ? {1'b0, sweep_per} : 4'd8;
                  if (state_in.sweep_on && (sweep_per != 3'd0)) begin
                     nf_first = sweep_calc(state_in.shadow_freq, state_in.sweep_reg);
                     if (nf_first > 13'd2047) begin
                        state_in.enabled = 1'b0;
                     end else if (state_in.sweep_reg[2:0] != 3'd0) begin
                        state_in.freq_low_reg     = nf_first[7:0];
                        state_in.trigger_reg[2:0] = nf_first[10:8];
                        state_in.shadow_freq      = nf_first[11:0];
                        nf_second = sweep_calc(nf_first[11:0], state_in.sweep_reg);
                        if (nf_second > 13'd2047) begin
                           state_in.enabled = 1'b0;
                        end
                     end
                  end
               end
            end

            if (run_env && (state_in.envelope_reg[2:0] != 3'd0)) begin
               if (state_in.period_timer != 3'd0) begin
                  state_in.period_timer = state_in.period_timer - 3'd1;
               end
               if (state_in.period_timer == 3'd0) begin
                  state_in.period_timer = state_in.envelope_reg[2:0];
                  if (state_in.envelope_reg[3]) begin
                     if (state_in.cur_volume != 4'hF) begin
                        state_in.cur_volume = state_in.cur_volume + 4'd1;
                     end
                  end else if (state_in.cur_volume != 4'd0) begin
                     state_in.cur_volume = state_in.cur_volume - 4'd1;
                  end
               end
            end

            timer_next = (state_in.freq_timer >= 15'd4) ? state_in.freq_timer - 15'd4 : '0;
            if (timer_next == 15'd0) begin
               state_in.duty_pos = state_in.duty_pos + 3'd1;
               timer_next = timer_period(state_in.trigger_reg, state_in.freq_low_reg);
            end
            state_in.freq_timer = timer_next;

            if (run_len && state_in.trigger_reg[6]) begin
               if (state_in.length_count != 7'd0) begin
                  state_in.length_count = state_in.length_count - 7'd1;
               end
               if (state_in.length_count == 7'd0) begin
                  state_in.enabled = 1'b0;
               end
            end
         end

         KIND_WRITE: begin
            unique case (item.reg_offset)
               OFF_SWEEP: begin
                  state_in.sweep_reg = item.write_data;
               end
               OFF_DUTY: begin
                  state_in.duty_reg     = item.write_data;
                  state_in.length_count = 7'd64 - {1'b0, item.write_data[5:0]};
               end
               OFF_ENVELOPE: begin
                  state_in.envelope_reg = item.write_data;
                  if (item.write_data[7:3] == 5'd0) begin
                     state_in.enabled = 1'b0;
                  end
               end
               OFF_FREQ_LOW: begin
                  state_in.freq_low_reg = item.write_data;
               end
               OFF_TRIGGER: begin
                  state_in.trigger_reg = item.write_data;
                  if (item.write_data[7]) begin
                     state_in.enabled     = 1'b1;
                     state_in.shadow_freq = {1'b0, item.write_data[2:0], state_ff.freq_low_reg};
                     state_in.sweep_timer = (sweep_per != 3'd0) ? {1'b0, sweep_per} : 4'd8;
                     state_in.sweep_on    = (sweep_per != 3'd0) ||
                                            (state_ff.sweep_reg[2:0] != 3'd0);
                     state_in.freq_timer  = timer_period(item.write_data,
                                                         state_ff.freq_low_reg);
                     state_in.period_timer = state_ff.envelope_reg[2:0];
                     state_in.cur_volume   = state_ff.envelope_reg[7:4];
                     if (state_ff.length_count == 7'd0) begin
                        state_in.length_count = 7'd64;
                     end
                     if (state_ff.envelope_reg[7:3] == 5'd0) begin
                        state_in.enabled = 1'b0;
                     end
                     if (state_ff.sweep_reg[2:0] != 3'd0) begin
                        nf_first = sweep_calc(state_in.shadow_freq, state_ff.sweep_reg);
                        if (nf_first > 13'd2047) begin
                           state_in.enabled = 1'b0;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         KIND_READ: begin
            unique case (item.reg_offset)
               OFF_SWEEP:    rd = state_ff.sweep_reg | 8'h80;
               OFF_DUTY:     rd = state_ff.duty_reg | 8'h3F;
               OFF_ENVELOPE: rd = state_ff.envelope_reg;
               OFF_TRIGGER:  rd = state_ff.trigger_reg | 8'hBF;
               default:      rd = 8'hFF;
            endcase
         end

         default: begin
         end
      endcase

      duty_bit = DUTY_TABLE[state_in.duty_reg[7:6]][state_in.duty_pos];
      result.amplitude  = (state_in.enabled && duty_bit) ? state_in.cur_volume : 4'd0;
      result.channel_on = state_in.enabled;
      result.read_data  = rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (item_go) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/square_channel_with_sweep_top.sv
// Top level of the square channel with frequency sweep: input item register,
// channel core and result register. Depends on sqsw_pkg, sqsw_if, sqsw_chan.
`timescale 1ns / 1ps
`default_nettype none

// Square-wave sound channel with sweep, length counter and volume envelope.
// Each request item (tick, register write or register read) yields exactly
// one response item with the amplitude and enable flag after that item and
// the read byte (255 when not a read). The block takes one item per clock:
// an item is held in the input register, its whole update runs in one
// pass through the channel core, and the result lands in the output register,
// so throughput is one item per cycle while the response side keeps ready
// high. A held response stalls the input register only once it is full.
module square_channel_with_sweep_top (
   input wire logic   clock,
   input wire logic   reset,
   sqsw_req_if.sink   req_chan,
   sqsw_rsp_if.source rsp_chan
);
   import sqsw_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   req_item_type s1_item_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   rsp_item_type core_result;
   req_item_type req_item;
   logic         s1_advance;
   logic         req_fire;

   assign req_item.kind       = req_chan.kind;
   assign req_item.fs_edge    = req_chan.fs_edge;
   assign req_item.reg_offset = req_chan.reg_offset;
   assign req_item.write_data = req_chan.write_data;

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   sqsw_chan u_chan (
      .clock   (clock),
      .reset   (reset),
      .item_go (s1_advance),
      .item    (s1_item_ff),
      .result  (core_result)
   );

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_item_in   = req_fire ? req_item : s1_item_ff;
      out_valid_in = s1_advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_item_in  = s1_advance ? core_result : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.amplitude  = out_item_ff.amplitude;
   assign rsp_chan.channel_on = out_item_ff.channel_on;
   assign rsp_chan.read_data  = out_item_ff.read_data;

endmodule

`default_nettype wire
